>>> rtl/ppmsp_pkg.sv
`default_nettype none

package ppmsp_pkg;

  localparam int unsigned MAX_DIM = 16384;
  localparam int unsigned DIM_CAP = (MAX_DIM < 16384) ? MAX_DIM : 16384;

  localparam int DIM_W = 15;
  localparam int CNT_W = 14;
  localparam int TOK_W = 20;
  localparam int ACC_W = TOK_W + 4;

  localparam logic [TOK_W-1:0] TOKEN_CAP   = '1;
  localparam logic [DIM_W-1:0] LIMIT_CAP   = DIM_W'(DIM_CAP);
  localparam logic [DIM_W-1:0] CFG_DIM_RST = 15'd16384;
  localparam logic [DIM_W-1:0] DIM_SAT     = 15'h7FFF;
  localparam logic [TOK_W-1:0] DEPTH_OK    = 20'd255;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_MAGIC_P,
    PH_MAGIC_D,
    PH_WIDTH,
    PH_HEIGHT,
    PH_MAXVAL,
    PH_ASCII,
    PH_BINARY,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_PIXEL,
    KIND_ERROR
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_MALFORMED,
    ST_BAD_TYPE,
    ST_BAD_DEPTH,
    ST_BAD_SIZE
  } status_e;

  typedef enum logic [1:0] {
    CFG_MAX_WIDTH,
    CFG_MAX_HEIGHT
  } cfg_index_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [CNT_W-1:0] pixel_x;
    logic [CNT_W-1:0] pixel_y;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [2:0]       status;
    logic             final_pixel;
  } out_word_t;

  typedef struct packed {
    logic is_digit;
    logic is_ws;
    logic is_hash;
    logic is_lf;
    logic is_p;
    logic is_three;
    logic is_six;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eof;
    byte_class_t cls;
  } cls_word_t;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    c.is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    c.is_ws    = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
                 (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    c.is_hash  = (b == CH_HASH);
    c.is_lf    = (b == CH_LF);
    c.is_p     = (b == CH_P);
    c.is_three = (b == CH_THREE);
    c.is_six   = (b == CH_SIX);
    return c;
  endfunction

  function automatic logic [DIM_W-1:0] limit_of(input logic [DIM_W-1:0] r);
    return (r > LIMIT_CAP) ? LIMIT_CAP : r;
  endfunction

  function automatic logic [DIM_W-1:0] sat15(input logic [TOK_W-1:0] v);
    return (v > TOK_W'(DIM_SAT)) ? DIM_SAT : v[DIM_W-1:0];
  endfunction

  function automatic status_e hdr_status(input logic [TOK_W-1:0] w,
                                         input logic [TOK_W-1:0] h,
                                         input logic [TOK_W-1:0] m,
                                         input logic [DIM_W-1:0] lw,
                                         input logic [DIM_W-1:0] lh);
    status_e st;
    if ((w == '0) || (h == '0) || (w > TOK_W'(lw)) || (h > TOK_W'(lh))) begin
      st = ST_BAD_SIZE;
    end else if (m != DEPTH_OK) begin
      st = ST_BAD_DEPTH;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ppmsp_front.sv
`default_nettype none

module ppmsp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ppmsp_pkg::in_word_t  in_i,
  output logic                 full_o,
  output logic                 word_valid_o,
  output ppmsp_pkg::cls_word_t word_o,
  input  logic                 word_take_i
);
  import ppmsp_pkg::*;

  cls_word_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       wr, rd;

  assign full_o       = (count_q == 2'd2);
  assign word_valid_o = (count_q != 2'd0);
  assign word_o       = mem_q[rd_ptr_q];
  assign wr           = push_i && !full_o;
  assign rd           = word_take_i && word_valid_o;

  always_comb begin
    wr_ptr_d = wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd ? ~rd_ptr_q : rd_ptr_q;
    unique case ({wr, rd})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= '{data: in_i.data_byte, eof: in_i.end_of_file,
                           cls: classify(in_i.data_byte)};
    end
  end

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !word_valid_o) |=> word_valid_o)
    else $error("accepted word not visible to back end");

endmodule

`default_nettype wire

>>> rtl/ppmsp_outq.sv
`default_nettype none

module ppmsp_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  ppmsp_pkg::out_word_t wr_data_i,
  output logic                 room_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output ppmsp_pkg::out_word_t rd_data_o
);
  import ppmsp_pkg::*;

  out_word_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       rd;

  assign empty_o   = (count_q == 2'd0);
  assign rd        = pop_i && !empty_o;
  assign room_o    = (count_q != 2'd2) || rd;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd ? ~rd_ptr_q : rd_ptr_q;
    unique case ({wr_i, rd})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> ((count_q != 2'd2) || rd))
    else $error("result written into full queue");

endmodule

`default_nettype wire

>>> rtl/ppmsp_back.sv
`default_nettype none

module ppmsp_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           word_valid_i,
  input  ppmsp_pkg::cls_word_t           word_i,
  output logic                           word_take_o,
  input  logic                           room_i,
  input  logic [ppmsp_pkg::DIM_W-1:0]    lim_w_i,
  input  logic [ppmsp_pkg::DIM_W-1:0]    lim_h_i,
  output logic                           res_valid_o,
  output ppmsp_pkg::out_word_t           res_o
);
  import ppmsp_pkg::*;

  phase_e           phase_q, phase_d;
  logic             binary_q, binary_d;
  logic             inc_q, inc_d;
  logic [TOK_W-1:0] tok_q, tok_d;
  logic             has_q, has_d;
  logic [DIM_W-1:0] width_q, width_d;
  logic [DIM_W-1:0] height_q, height_d;
  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [1:0]       chan_q, chan_d;
  logic [7:0]       red_q, red_d;
  logic [7:0]       green_q, green_d;

  byte_class_t      cls;
  logic             sep;
  logic [ACC_W-1:0] acc;
  logic [TOK_W-1:0] acc_sat;
  logic             last_q;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] y_full;
  status_e          hs_height;
  status_e          hs_maxval;
  status_e          early_st;
  logic             eof_take;
  logic             take_s;
  logic [7:0]       samp;
  logic             err;
  status_e          err_st;

  assign word_take_o = word_valid_i && room_i;
  assign cls         = word_i.cls;
  assign sep         = cls.is_ws || cls.is_hash;
  assign acc         = ({{(ACC_W-TOK_W){1'b0}}, tok_q} << 3) +
                       ({{(ACC_W-TOK_W){1'b0}}, tok_q} << 1) +
                       ACC_W'(word_i.data[3:0]);
  assign acc_sat     = (acc > ACC_W'(TOKEN_CAP)) ? TOKEN_CAP : acc[TOK_W-1:0];
  assign last_q      = (({1'b0, row_q} + 15'd1) == height_q) &&
                       (({1'b0, col_q} + 15'd1) == width_q);
  assign col_inc     = {1'b0, col_q} + 15'd1;
  assign y_full      = height_q - 15'd1 - {1'b0, row_q};
  assign hs_height   = hdr_status(TOK_W'(width_q), tok_q, '0, lim_w_i, lim_h_i);
  assign hs_maxval   = hdr_status(TOK_W'(width_q), TOK_W'(height_q), tok_q, lim_w_i, lim_h_i);
  assign eof_take    = word_i.eof && (phase_q == PH_ASCII) && !inc_q && cls.is_digit &&
                       (chan_q == 2'd2) && last_q;

  always_comb begin
    phase_d     = phase_q;
    binary_d    = binary_q;
    inc_d       = inc_q;
    tok_d       = tok_q;
    has_d       = has_q;
    width_d     = width_q;
    height_d    = height_q;
    col_d       = col_q;
    row_d       = row_q;
    chan_d      = chan_q;
    red_d       = red_q;
    green_d     = green_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    take_s      = 1'b0;
    samp        = word_i.data;
    err         = 1'b0;
    err_st      = ST_OK;
    early_st    = ST_MALFORMED;

    unique case (phase_q)
      PH_MAGIC_P: begin
        if (inc_q) begin
          if (cls.is_lf) inc_d = 1'b0;
        end else if (cls.is_ws) begin
          inc_d = inc_q;
        end else if (cls.is_hash) begin
          inc_d = 1'b1;
        end else if (cls.is_p) begin
          phase_d = PH_MAGIC_D;
        end else begin
          err    = 1'b1;
          err_st = ST_BAD_TYPE;
        end
      end
      PH_MAGIC_D: begin
        if (cls.is_three || cls.is_six) begin
          binary_d = cls.is_six;
          phase_d  = PH_WIDTH;
          tok_d    = '0;
          has_d    = 1'b0;
        end else begin
          err    = 1'b1;
          err_st = ST_BAD_TYPE;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        if (inc_q) begin
          if (cls.is_lf) inc_d = 1'b0;
        end else if (cls.is_digit) begin
          tok_d = acc_sat;
          has_d = 1'b1;
        end else if (sep && !has_q) begin
          if (cls.is_hash) inc_d = 1'b1;
        end else if (phase_q != PH_MAXVAL) begin
          if (!sep) begin
            err    = 1'b1;
            err_st = (phase_q == PH_WIDTH) ? ST_BAD_SIZE : hs_height;
          end else begin
            if (phase_q == PH_WIDTH) begin
              width_d = sat15(tok_q);
              phase_d = PH_HEIGHT;
            end else begin
              height_d = sat15(tok_q);
              phase_d  = PH_MAXVAL;
            end
            if (cls.is_hash) inc_d = 1'b1;
            tok_d = '0;
            has_d = 1'b0;
          end
        end else if (hs_maxval != ST_OK) begin
          err    = 1'b1;
          err_st = hs_maxval;
        end else if (!binary_q && !sep) begin
          err    = 1'b1;
          err_st = ST_MALFORMED;
        end else begin
          tok_d  = '0;
          has_d  = 1'b0;
          col_d  = '0;
          row_d  = '0;
          chan_d = 2'd0;
          if (binary_q) begin
            phase_d = PH_BINARY;
          end else begin
            phase_d = PH_ASCII;
            if (cls.is_hash) inc_d = 1'b1;
          end
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_HEADER;
          res_o.image_width  = width_q;
          res_o.image_height = height_q;
        end
      end
      PH_ASCII: begin
        if (inc_q) begin
          if (cls.is_lf) inc_d = 1'b0;
        end else if (cls.is_digit) begin
          tok_d = acc[TOK_W-1:0];
          has_d = 1'b1;
        end else if (has_q) begin
          tok_d = '0;
          has_d = 1'b0;
          if (!sep && !((chan_q == 2'd2) && last_q)) begin
            err    = 1'b1;
            err_st = ST_MALFORMED;
          end else begin
            take_s = 1'b1;
            samp   = tok_q[7:0];
            if (cls.is_hash) inc_d = 1'b1;
          end
        end else if (!sep) begin
          err    = 1'b1;
          err_st = ST_MALFORMED;
        end else if (cls.is_hash) begin
          inc_d = 1'b1;
        end
      end
      PH_BINARY: begin
        take_s = 1'b1;
        samp   = word_i.data;
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
    endcase

    if (eof_take) begin
      take_s = 1'b1;
      samp   = acc[7:0];
    end

    if (take_s) begin
      unique case (chan_q)
        2'd0: begin
          red_d  = samp;
          chan_d = 2'd1;
        end
        2'd1: begin
          green_d = samp;
          chan_d  = 2'd2;
        end
        default: begin
          chan_d            = 2'd0;
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_PIXEL;
          res_o.pixel_x     = col_q;
          res_o.pixel_y     = y_full[CNT_W-1:0];
          res_o.red         = red_q;
          res_o.green       = green_q;
          res_o.blue        = samp;
          res_o.final_pixel = last_q;
          if (last_q) begin
            phase_d = PH_DONE;
          end else if (col_inc >= width_q) begin
            col_d = '0;
            row_d = row_q + 14'd1;
          end else begin
            col_d = col_inc[CNT_W-1:0];
          end
        end
      endcase
    end

    if (err) begin
      phase_d      = PH_DONE;
      res_valid_o  = 1'b1;
      res_o        = '0;
      res_o.kind   = KIND_ERROR;
      res_o.status = err_st;
    end

    if (word_i.eof) begin
      priority case (phase_d)
        PH_MAGIC_P, PH_MAGIC_D: early_st = ST_BAD_TYPE;
        PH_WIDTH:               early_st = ST_BAD_SIZE;
        PH_HEIGHT:
          early_st = hdr_status(TOK_W'(width_d), tok_d, '0, lim_w_i, lim_h_i);
        PH_MAXVAL: begin
          early_st = hdr_status(TOK_W'(width_d), TOK_W'(height_d), tok_d, lim_w_i, lim_h_i);
          if (early_st == ST_OK) early_st = ST_MALFORMED;
        end
        default:                early_st = ST_MALFORMED;
      endcase
      if (!eof_take && (phase_d != PH_DONE)) begin
        res_valid_o  = 1'b1;
        res_o        = '0;
        res_o.kind   = KIND_ERROR;
        res_o.status = early_st;
      end
      phase_d  = PH_MAGIC_P;
      binary_d = 1'b0;
      inc_d    = 1'b0;
      tok_d    = '0;
      has_d    = 1'b0;
      width_d  = '0;
      height_d = '0;
      col_d    = '0;
      row_d    = '0;
      chan_d   = 2'd0;
      red_d    = '0;
      green_d  = '0;
    end

    if (!word_take_o) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC_P;
      binary_q <= 1'b0;
      inc_q    <= 1'b0;
      tok_q    <= '0;
      has_q    <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      chan_q   <= 2'd0;
      red_q    <= '0;
      green_q  <= '0;
    end else if (word_take_o) begin
      phase_q  <= phase_d;
      binary_q <= binary_d;
      inc_q    <= inc_d;
      tok_q    <= tok_d;
      has_q    <= has_d;
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      chan_q   <= chan_d;
      red_q    <= red_d;
      green_q  <= green_d;
    end
  end

  a_eof_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_take_o && word_i.eof) |=> ((phase_q == PH_MAGIC_P) && (chan_q == 2'd0)))
    else $error("parser not restarted after end of file");

  a_pixel_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_ASCII) || (phase_q == PH_BINARY)) |->
      (({1'b0, col_q} < width_q) && ({1'b0, row_q} < height_q)))
    else $error("pixel position outside image");

  a_result_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (word_valid_i && room_i))
    else $error("result produced without a consumed word");

endmodule

`default_nettype wire

>>> rtl/ppm_image_stream_parser_core.sv
// Channel   Handshake                  Payload
// input     push / full                in_i   : data_byte, end_of_file
// result    empty / pop                out_o  : kind .. final_pixel
// config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i (15 bit)
//
// One byte per cycle sustained while the result queue has room; the parser state update is the single loop.
// A byte is classified into the byte queue, then parsed, and any result it gives
// is written into the result queue. Both queues hold two words.
// Reset empties both queues, restarts the parser and sets both limits to 16384.
// With pop held low the result queue fills, the parser stalls, then full rises.
`default_nettype none

module ppm_image_stream_parser_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  ppmsp_pkg::in_word_t            in_i,
  output logic                           full,
  output logic                           empty,
  input  logic                           pop,
  output ppmsp_pkg::out_word_t           out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [ppmsp_pkg::DIM_W-1:0]    cfg_data_i
);
  import ppmsp_pkg::*;

  logic [DIM_W-1:0] max_w_q, max_w_d;
  logic [DIM_W-1:0] max_h_q, max_h_d;
  logic             word_valid;
  cls_word_t        word;
  logic             word_take;
  logic             room;
  logic             res_valid;
  out_word_t        res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    max_w_d = max_w_q;
    max_h_d = max_h_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_MAX_WIDTH) max_w_d = cfg_data_i;
      if (cfg_index_i == CFG_MAX_HEIGHT) max_h_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_w_q <= CFG_DIM_RST;
      max_h_q <= CFG_DIM_RST;
    end else begin
      max_w_q <= max_w_d;
      max_h_q <= max_h_d;
    end
  end

  ppmsp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .in_i         (in_i),
    .full_o       (full),
    .word_valid_o (word_valid),
    .word_o       (word),
    .word_take_i  (word_take)
  );

  ppmsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (word_valid),
    .word_i       (word),
    .word_take_o  (word_take),
    .room_i       (room),
    .lim_w_i      (limit_of(max_w_q)),
    .lim_h_i      (limit_of(max_h_q)),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ppmsp_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_valid),
    .wr_data_i (res),
    .room_o    (room),
    .pop_i     (pop),
    .empty_o   (empty),
    .rd_data_o (out_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/ppm_image_stream_parser_core_tb.sv
`timescale 1ns / 1ps

module ppm_image_stream_parser_core_tb;
  import ppmsp_pkg::*;

  localparam int TOK_MAX     = 'hFFFFF;
  localparam int CYCLE_CAP   = 500000;
  localparam int PHASE_BYTES = 180;

  typedef struct packed {
    in_word_t  word;
    logic      typed;
    logic      has;
    out_word_t res;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  in_word_t             in_i = '0;
  logic                 full;
  logic                 empty;
  logic                 pop = 1'b0;
  out_word_t            out_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [1:0]           cfg_index_i = '0;
  logic [DIM_W-1:0]     cfg_data_i = '0;

  ppm_image_stream_parser_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_i       (in_i),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // parser model state and limit registers
  logic [DIM_W-1:0] lim_w, lim_h;
  phase_e           ps_phase;
  bit               ps_bin, ps_cmt, ps_dig;
  int               ps_tok, ps_w, ps_h, ps_col, ps_row, ps_chan;
  logic [7:0]       ps_red, ps_green;

  out_word_t  pending_results[$];
  logic [7:0] file_q[$];
  dir_row_t   dir_q[$];

  bit tx_calm, rx_calm;
  int n_fail, n_popped, n_sent, n_bytes, n_files, n_cfg;
  int n_hdr, n_pix, n_errs;

  function automatic bit is_space(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT || b == CH_FF ||
           b == CH_CR;
  endfunction

  function automatic bit is_num(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic int dim_limit(logic [DIM_W-1:0] lim);
    int l;
    l = lim;
    if (l > MAX_DIM) l = MAX_DIM;
    if (l > 16384) l = 16384;
    return l;
  endfunction

  function automatic int sat_dim(int v);
    return (v > 32767) ? 32767 : v;
  endfunction

  function automatic status_e hdr_check(int w, int h, int m);
    if (w == 0 || h == 0 || w > dim_limit(lim_w) || h > dim_limit(lim_h)) return ST_BAD_SIZE;
    if (m != 255) return ST_BAD_DEPTH;
    return ST_OK;
  endfunction

  function automatic out_word_t mk(kind_e k, int w, int h, int x, int y, int rd, int gr,
                                   int bl, status_e st, bit fin);
    out_word_t r;
    r.kind         = k;
    r.image_width  = w[DIM_W-1:0];
    r.image_height = h[DIM_W-1:0];
    r.pixel_x      = x[CNT_W-1:0];
    r.pixel_y      = y[CNT_W-1:0];
    r.red          = rd[7:0];
    r.green        = gr[7:0];
    r.blue         = bl[7:0];
    r.status       = st;
    r.final_pixel  = fin;
    return r;
  endfunction

  function automatic out_word_t err_word(status_e st);
    return mk(KIND_ERROR, 0, 0, 0, 0, 0, 0, 0, st, 1'b0);
  endfunction

  function automatic void clear_file();
    ps_phase = PH_MAGIC_P;
    ps_bin   = 1'b0;
    ps_cmt   = 1'b0;
    ps_tok   = 0;
    ps_dig   = 1'b0;
    ps_w     = 0;
    ps_h     = 0;
    ps_col   = 0;
    ps_row   = 0;
    ps_chan  = 0;
    ps_red   = '0;
    ps_green = '0;
  endfunction

  function automatic bit raise_err(status_e st, output out_word_t r);
    r = err_word(st);
    ps_phase = PH_DONE;
    return 1'b1;
  endfunction

  function automatic bit last_px();
    return ps_row + 1 == ps_h && ps_col + 1 == ps_w;
  endfunction

  function automatic bit store_sample(logic [7:0] v, output out_word_t r);
    bit fin;
    r = '0;
    if (ps_chan == 0) begin
      ps_red = v;
      ps_chan = 1;
      return 1'b0;
    end
    if (ps_chan == 1) begin
      ps_green = v;
      ps_chan = 2;
      return 1'b0;
    end
    ps_chan = 0;
    fin = last_px();
    r = mk(KIND_PIXEL, 0, 0, ps_col, ps_h - 1 - ps_row, int'(ps_red), int'(ps_green), int'(v),
           ST_OK, fin);
    if (fin) begin
      ps_phase = PH_DONE;
    end else begin
      ps_col++;
      if (ps_col >= ps_w) begin
        ps_col = 0;
        ps_row++;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit header_byte(logic [7:0] b, output out_word_t r);
    bit      sep;
    status_e st;
    int      v;
    sep = is_space(b) || b == CH_HASH;
    r = '0;
    if (ps_cmt) begin
      if (b == CH_LF) ps_cmt = 1'b0;
      return 1'b0;
    end
    if (is_num(b)) begin
      v = ps_tok * 10 + int'(b - CH_ZERO);
      ps_tok = (v > TOK_MAX) ? TOK_MAX : v;
      ps_dig = 1'b1;
      return 1'b0;
    end
    if (sep && !ps_dig) begin
      if (b == CH_HASH) ps_cmt = 1'b1;
      return 1'b0;
    end
    if (ps_phase == PH_WIDTH || ps_phase == PH_HEIGHT) begin
      if (!sep) begin
        if (ps_phase == PH_WIDTH) return raise_err(hdr_check(ps_tok, 0, 0), r);
        return raise_err(hdr_check(ps_w, ps_tok, 0), r);
      end
      if (ps_phase == PH_WIDTH) begin
        ps_w = sat_dim(ps_tok);
        ps_phase = PH_HEIGHT;
      end else begin
        ps_h = sat_dim(ps_tok);
        ps_phase = PH_MAXVAL;
      end
      if (b == CH_HASH) ps_cmt = 1'b1;
      ps_tok = 0;
      ps_dig = 1'b0;
      return 1'b0;
    end
    st = hdr_check(ps_w, ps_h, ps_tok);
    if (st != ST_OK) return raise_err(st, r);
    if (!ps_bin && !sep) return raise_err(ST_MALFORMED, r);
    ps_tok  = 0;
    ps_dig  = 1'b0;
    ps_col  = 0;
    ps_row  = 0;
    ps_chan = 0;
    if (ps_bin) begin
      ps_phase = PH_BINARY;
    end else begin
      ps_phase = PH_ASCII;
      if (b == CH_HASH) ps_cmt = 1'b1;
    end
    r = mk(KIND_HEADER, ps_w, ps_h, 0, 0, 0, 0, 0, ST_OK, 1'b0);
    return 1'b1;
  endfunction

  function automatic bit ascii_byte(logic [7:0] b, output out_word_t r);
    bit sep, last, n;
    int v;
    sep = is_space(b) || b == CH_HASH;
    r = '0;
    n = 1'b0;
    if (ps_cmt) begin
      if (b == CH_LF) ps_cmt = 1'b0;
      return 1'b0;
    end
    if (is_num(b)) begin
      ps_tok = (ps_tok * 10 + int'(b - CH_ZERO)) & TOK_MAX;
      ps_dig = 1'b1;
      return 1'b0;
    end
    if (ps_dig) begin
      v = ps_tok;
      last = ps_chan == 2 && last_px();
      ps_tok = 0;
      ps_dig = 1'b0;
      if (!sep && !last) return raise_err(ST_MALFORMED, r);
      n = store_sample(v[7:0], r);
      if (ps_phase == PH_DONE) return n;
    end else if (!sep) begin
      return raise_err(ST_MALFORMED, r);
    end
    if (b == CH_HASH) ps_cmt = 1'b1;
    return n;
  endfunction

  function automatic status_e eof_status();
    status_e st;
    case (ps_phase)
      PH_MAGIC_P, PH_MAGIC_D: return ST_BAD_TYPE;
      PH_WIDTH: return hdr_check(ps_tok, 0, 0);
      PH_HEIGHT: return hdr_check(ps_w, ps_tok, 0);
      PH_MAXVAL: begin
        st = hdr_check(ps_w, ps_h, ps_tok);
        if (st != ST_OK) return st;
        return ST_MALFORMED;
      end
      default: return ST_MALFORMED;
    endcase
  endfunction

  function automatic bit parse_byte(in_word_t w, output out_word_t r);
    logic [7:0] b;
    bit         n;
    b = w.data_byte;
    r = '0;
    n = 1'b0;
    case (ps_phase)
      PH_MAGIC_P: begin
        if (ps_cmt) begin
          if (b == CH_LF) ps_cmt = 1'b0;
        end else if (b == CH_HASH) begin
          ps_cmt = 1'b1;
        end else if (b == CH_P) begin
          ps_phase = PH_MAGIC_D;
        end else if (!is_space(b)) begin
          n = raise_err(ST_BAD_TYPE, r);
        end
      end
      PH_MAGIC_D: begin
        if (b == CH_THREE || b == CH_SIX) begin
          ps_bin = (b == CH_SIX);
          ps_phase = PH_WIDTH;
          ps_tok = 0;
          ps_dig = 1'b0;
        end else begin
          n = raise_err(ST_BAD_TYPE, r);
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: n = header_byte(b, r);
      PH_ASCII: n = ascii_byte(b, r);
      PH_BINARY: n = store_sample(b, r);
      default: n = 1'b0;
    endcase
    if (w.end_of_file) begin
      if (ps_phase != PH_DONE) begin
        if (ps_phase == PH_ASCII && !n && ps_dig && !ps_cmt && ps_chan == 2 && last_px()) begin
          n = store_sample(ps_tok[7:0], r);
        end else begin
          n = raise_err(eof_status(), r);
        end
      end
      clear_file();
    end
    return n;
  endfunction

  function automatic void add_dir(logic [7:0] b, bit eof, bit typed, bit has, out_word_t res);
    dir_row_t d;
    d.word.data_byte   = b;
    d.word.end_of_file = eof;
    d.typed            = typed;
    d.has              = has;
    d.res              = res;
    dir_q.push_back(d);
  endfunction

  function automatic logic [7:0] ws_char();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic void put_sep();
    logic [7:0] c;
    bit         cmt_first;
    cmt_first = ($urandom_range(0, 1) == 1);
    if (cmt_first || $urandom_range(0, 6) != 0) begin
      repeat ($urandom_range(1, 2)) file_q.push_back(ws_char());
    end
    if (cmt_first || $urandom_range(0, 7) == 0) begin
      file_q.push_back(CH_HASH);
      repeat ($urandom_range(0, 5)) begin
        do c = 8'($urandom); while (c == CH_LF);
        file_q.push_back(c);
      end
      file_q.push_back(CH_LF);
    end
    if (file_q[file_q.size() - 1] != CH_LF && !is_space(file_q[file_q.size() - 1])) begin
      file_q.push_back(ws_char());
    end
  endfunction

  function automatic void put_num(int v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) file_q.push_back(CH_ZERO);
    for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endfunction

  function automatic int pick_dim(logic [DIM_W-1:0] lim);
    case ($urandom_range(0, 19))
      0: return 0;
      1: return dim_limit(lim);
      2: return dim_limit(lim) + 1;
      3: return $urandom_range(0, 9999999);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(256, 99999);
      1: return $urandom_range(0, 9999999);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic void gen_file();
    int         w, h, mx, npix, style;
    bit         bin;
    logic [7:0] c;
    file_q.delete();
    style = $urandom_range(0, 19);
    if (style == 0) begin
      if ($urandom_range(0, 1) == 1) file_q.push_back(CH_P);
      repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
      return;
    end
    bin = ($urandom_range(0, 1) == 1);
    w   = pick_dim(lim_w);
    h   = pick_dim(lim_h);
    mx  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : 255;
    if ($urandom_range(0, 7) == 0) put_sep();
    file_q.push_back(CH_P);
    file_q.push_back(style == 1 ? 8'($urandom) : (bin ? CH_SIX : CH_THREE));
    put_sep();
    put_num(w);
    put_sep();
    put_num(h);
    put_sep();
    put_num(mx);
    if (bin) begin
      if ($urandom_range(0, 3) == 0) begin
        do c = 8'($urandom); while (is_num(c));
        file_q.push_back(c);
      end else begin
        file_q.push_back(ws_char());
      end
    end else if ($urandom_range(0, 15) == 0) begin
      do c = 8'($urandom); while (is_num(c) || is_space(c) || c == CH_HASH);
      file_q.push_back(c);
    end else begin
      put_sep();
    end
    npix = (longint'(w) * h > 16) ? $urandom_range(1, 16) : w * h;
    for (int i = 0; i < npix * 3; i++) begin
      if (bin) begin
        file_q.push_back(8'($urandom));
      end else begin
        put_num(pick_sample());
        if (i != npix * 3 - 1) begin
          put_sep();
        end else begin
          case ($urandom_range(0, 2))
            0: ;
            1: put_sep();
            default: begin
              do c = 8'($urandom); while (is_num(c) || is_space(c) || c == CH_HASH);
              file_q.push_back(c);
            end
          endcase
        end
      end
    end
    if (file_q.size() == 0) file_q.push_back(CH_SPACE);
    case (style)
      2: begin
        npix = $urandom_range(1, file_q.size());
        while (file_q.size() > npix) void'(file_q.pop_back());
      end
      3: file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
      4: repeat ($urandom_range(1, 8)) file_q.push_back(8'($urandom));
      default: ;
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    n_fail++;
    if (n_fail <= 30) begin
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_popped);
    end
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (pending_results.size() == 0) begin
      report("result with none pending, kind", 32'(got.kind), 0);
      return;
    end
    want = pending_results.pop_front();
    case (want.kind)
      KIND_HEADER: n_hdr++;
      KIND_PIXEL: n_pix++;
      default: n_errs++;
    endcase
    if (got.kind !== want.kind) report("kind", 32'(got.kind), 32'(want.kind));
    if (got.image_width !== want.image_width)
      report("image_width", 32'(got.image_width), 32'(want.image_width));
    if (got.image_height !== want.image_height)
      report("image_height", 32'(got.image_height), 32'(want.image_height));
    if (got.pixel_x !== want.pixel_x)
      report("pixel_x", 32'(got.pixel_x), 32'(want.pixel_x));
    if (got.pixel_y !== want.pixel_y)
      report("pixel_y", 32'(got.pixel_y), 32'(want.pixel_y));
    if (got.red !== want.red) report("red", 32'(got.red), 32'(want.red));
    if (got.green !== want.green) report("green", 32'(got.green), 32'(want.green));
    if (got.blue !== want.blue) report("blue", 32'(got.blue), 32'(want.blue));
    if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
    if (got.final_pixel !== want.final_pixel)
      report("final_pixel", 32'(got.final_pixel), 32'(want.final_pixel));
  endtask

  task automatic send_word(in_word_t w, output bit got, output out_word_t r);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    n_sent++;
    n_bytes++;
    got = parse_byte(w, r);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [DIM_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_MAX_WIDTH) lim_w = val;
    else lim_h = val;
    @(posedge clk_i);
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL ppm_image_stream_parser_core");
    $finish;
  end

  initial begin : receiver
    int gap, hold, holds;
    gap   = 0;
    hold  = 0;
    holds = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        check_word(out_o);
        n_popped++;
        gap = rx_calm ? 0 : $urandom_range(0, 11);
        if (holds < 2 && n_popped >= 20 * (holds + 1) && push) begin
          hold = 300;
          holds++;
        end
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    bit               got;
    out_word_t        r;
    in_word_t         w;
    logic [DIM_W-1:0] mw, mh;
    lim_w = CFG_DIM_RST;
    lim_h = CFG_DIM_RST;
    clear_file();

    add_dir("X", 1'b0, 1'b1, 1'b1, err_word(ST_BAD_TYPE));
    add_dir(8'hFF, 1'b1, 1'b1, 1'b0, '0);
    add_dir(CH_P, 1'b0, 1'b0, 1'b0, '0);
    add_dir(CH_SIX, 1'b0, 1'b0, 1'b0, '0);
    add_dir(CH_SPACE, 1'b0, 1'b0, 1'b0, '0);
    add_dir("1", 1'b0, 1'b0, 1'b0, '0);
    add_dir(CH_TAB, 1'b0, 1'b0, 1'b0, '0);
    add_dir("1", 1'b0, 1'b0, 1'b0, '0);
    add_dir(CH_LF, 1'b0, 1'b0, 1'b0, '0);
    add_dir("2", 1'b0, 1'b0, 1'b0, '0);
    add_dir("5", 1'b0, 1'b0, 1'b0, '0);
    add_dir("5", 1'b0, 1'b0, 1'b0, '0);
    add_dir(CH_CR, 1'b0, 1'b1, 1'b1, mk(KIND_HEADER, 1, 1, 0, 0, 0, 0, 0, ST_OK, 1'b0));
    add_dir(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_dir(8'hFF, 1'b0, 1'b0, 1'b0, '0);
    add_dir(8'h80, 1'b1, 1'b1, 1'b1,
            mk(KIND_PIXEL, 0, 0, 0, 0, 0, 255, 128, ST_OK, 1'b1));
    add_dir(CH_P, 1'b0, 1'b0, 1'b0, '0);
    add_dir("7", 1'b0, 1'b1, 1'b1, err_word(ST_BAD_TYPE));
    add_dir("Q", 1'b1, 1'b1, 1'b0, '0);
    add_dir(CH_P, 1'b0, 1'b0, 1'b0, '0);
    add_dir(CH_THREE, 1'b0, 1'b0, 1'b0, '0);
    add_dir(CH_SPACE, 1'b0, 1'b0, 1'b0, '0);
    add_dir(CH_ZERO, 1'b0, 1'b0, 1'b0, '0);
    add_dir(CH_HASH, 1'b1, 1'b1, 1'b1, err_word(ST_BAD_SIZE));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[i]) begin
      send_word(dir_q[i].word, got, r);
      if (dir_q[i].typed) begin
        if (dir_q[i].has) pending_results.push_back(dir_q[i].res);
      end else if (got) begin
        pending_results.push_back(r);
      end
    end
    n_files = 4;

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin mw = 15'd1; mh = 15'd1; end
        1: begin mw = 15'd3; mh = 15'd2; end
        2: begin mw = 15'd16384; mh = 15'd1; end
        3: begin mw = 15'($urandom_range(1, 16384)); mh = 15'($urandom_range(1, 16384)); end
        4: begin mw = 15'($urandom_range(1, 8)); mh = 15'($urandom_range(1, 8)); end
        default: begin mw = 15'd16384; mh = 15'd16384; end
      endcase
      write_reg(CFG_MAX_WIDTH, mw);
      write_reg(CFG_MAX_HEIGHT, mh);
      n_cfg++;
      n_sent = 0;
      while (n_sent < PHASE_BYTES) begin
        gen_file();
        n_files++;
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        foreach (file_q[i]) begin
          w.data_byte   = file_q[i];
          w.end_of_file = (i == file_q.size() - 1);
          send_word(w, got, r);
          if (got) pending_results.push_back(r);
        end
      end
    end
    drain();

    $display("Streamed %0d files in %0d bytes under %0d limit settings plus reset values",
             n_files, n_bytes, n_cfg);
    $display("Checked %0d headers, %0d pixels and %0d error words", n_hdr, n_pix, n_errs);
    if (n_fail == 0) begin
      $display("PASS ppm_image_stream_parser_core");
    end else begin
      $display("FAIL ppm_image_stream_parser_core");
    end
    $finish;
  end

endmodule
